// ----- src/rthsl_pkg.sv -----
package rthsl_pkg;

    localparam int IN_W  = 8;
    localparam int OUT_W = 16;

    // Numerator and denominator width of one divider lane (hue reaches 6 * 255).
    localparam int NUM_W = 11;
    localparam int DEN_W = 11;

    localparam int NUM_LANES = 2;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;

    localparam logic [9:0] LIGHT_DEN = 10'd510;
    localparam logic [8:0] HALF_SUM  = 9'd255;

    // Multiplying by LIT_RECIP and shifting right by LIT_RECIP_SHIFT divides any value
    // below 2^17 by 255 exactly.
    localparam logic [17:0] LIT_RECIP       = 18'd131587;
    localparam int          LIT_RECIP_SHIFT = 25;

    typedef struct packed {
        logic [IN_W-1:0] red;
        logic [IN_W-1:0] green;
        logic [IN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [OUT_W-1:0] lightness;
    } hsl_t;

endpackage

// ----- src/rgb_to_hsl_converter.sv -----
// RGB to HSL converter for an 8-bit pixel stream.
// Each pixel item enters on the pixel channel (pixel_valid, pixel_stall, pixel) and one
// item carrying hue, saturation and lightness leaves on the hsl channel (hsl_valid,
// hsl_stall, hsl). All three results are unsigned fractions in which 2^OUT_FRAC_BITS - 1
// means one, rounded to nearest with ties upward.
// The stages are an input register, a min/max stage, a stage that forms numerators and
// denominators, a stage that scales the numerators, and one restoring division stage per
// result bit, with hue and saturation lanes side by side. Lightness divides by a constant,
// so it is formed by a reciprocal multiplication in the scaling stage and the first
// division stage and then carried alongside the lanes.
// Throughput is one item per cycle unless the receiver stalls; one quotient bit per stage.
// A stalled receiver freezes only the last occupied stages; empty stages further up still
// fill, so the pixel channel is stalled only when every stage holds an item and the
// receiver stalls. Results leave straight from the last stage register.
// Reset empties the pipeline; no item is lost or repeated across a stall.
module rgb_to_hsl_converter
    import rthsl_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   hsl_valid,
    input  logic   hsl_stall,
    output hsl_t   hsl
);

    localparam int F  = OUT_FRAC_BITS;
    localparam int NW = F + 12;
    localparam int DW = DEN_W + 1;
    localparam int NS = F + 4;
    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_D = 3;
    localparam int LBW    = F + IN_W + 1;
    localparam int LIT_A  = (1 << F) / int'(LIGHT_DEN);
    localparam int LIT_B1 = (1 << F) % int'(LIGHT_DEN) - 1;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] adv;

    pixel_t a_pix_reg;

    logic [IN_W-1:0] b_red_reg;
    logic [IN_W-1:0] b_green_reg;
    logic [IN_W-1:0] b_blue_reg;
    logic [IN_W-1:0] b_max_reg;
    logic [IN_W-1:0] b_min_reg;
    logic            b_rmax_reg;
    logic            b_gmax_reg;
    logic [IN_W-1:0] b_max_next;
    logic [IN_W-1:0] b_min_next;
    logic            b_rmax_next;
    logic            b_gmax_next;

    logic [NUM_W-1:0] c_num_reg [NUM_LANES];
    logic [DEN_W-1:0] c_den_reg [NUM_LANES];
    logic [NUM_W-1:0] c_num_next [NUM_LANES];
    logic [DEN_W-1:0] c_den_next [NUM_LANES];
    logic [8:0]       c_sum_reg;

    logic [NW-1:0] rem_reg  [F+1][NUM_LANES];
    logic [DW-1:0] dvs_reg  [F+1][NUM_LANES];
    logic [F-1:0]  q_reg    [F+1][NUM_LANES];
    logic [NW-1:0] rem_next [F+1][NUM_LANES];
    logic [DW-1:0] dvs_next [F+1][NUM_LANES];
    logic [F-1:0]  q_next   [F+1][NUM_LANES];

    logic [LBW-1:0] lit_base_full;
    logic [18:0]    lit_z;
    logic [34:0]    lit_prod;
    logic [F-1:0]   d_lit_base_reg;
    logic [16:0]    d_lit_y_reg;
    logic [F-1:0]   d_lit_base_next;
    logic [16:0]    d_lit_y_next;
    logic [F-1:0]   lit_reg [F];
    logic [F-1:0]   lit_next;

    logic [IN_W-1:0] diff;
    logic [8:0]      sum;
    logic [12:0]     six_diff;
    logic [12:0]     hue_raw;
    logic [12:0]     hue_wrap;
    logic            grey;

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || !hsl_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? pixel_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign pixel_stall = !adv[0];

    always_comb
    begin
        b_rmax_next = (a_pix_reg.red >= a_pix_reg.green) && (a_pix_reg.red >= a_pix_reg.blue);
        b_gmax_next = !b_rmax_next && (a_pix_reg.green >= a_pix_reg.blue);
        priority if (b_rmax_next)
        begin
            b_max_next = a_pix_reg.red;
        end
        else if (b_gmax_next)
        begin
            b_max_next = a_pix_reg.green;
        end
        else
        begin
            b_max_next = a_pix_reg.blue;
        end
        b_min_next = a_pix_reg.red;
        if (a_pix_reg.green < b_min_next)
        begin
            b_min_next = a_pix_reg.green;
        end
        if (a_pix_reg.blue < b_min_next)
        begin
            b_min_next = a_pix_reg.blue;
        end
    end

    always_comb
    begin
        diff     = b_max_reg - b_min_reg;
        sum      = 9'(b_max_reg) + 9'(b_min_reg);
        grey     = (diff == '0);
        six_diff = (13'(diff) << 2) + (13'(diff) << 1);
        priority if (b_rmax_reg)
        begin
            hue_raw = 13'(b_green_reg) - 13'(b_blue_reg);
        end
        else if (b_gmax_reg)
        begin
            hue_raw = (13'(diff) << 1) + 13'(b_blue_reg) - 13'(b_red_reg);
        end
        else
        begin
            hue_raw = (13'(diff) << 2) + 13'(b_red_reg) - 13'(b_green_reg);
        end
        hue_wrap = hue_raw[12] ? hue_raw + six_diff : hue_raw;

        // A grey pixel divides zero by one, which yields zero hue and saturation.
        c_num_next[LANE_HUE] = grey ? '0 : NUM_W'(hue_wrap);
        c_den_next[LANE_HUE] = grey ? DEN_W'(1) : DEN_W'(six_diff);
        c_num_next[LANE_SAT] = grey ? '0 : NUM_W'(diff);
        if (grey)
        begin
            c_den_next[LANE_SAT] = DEN_W'(1);
        end
        else if (sum < HALF_SUM)
        begin
            c_den_next[LANE_SAT] = DEN_W'(sum);
        end
        else
        begin
            c_den_next[LANE_SAT] = DEN_W'(LIGHT_DEN - 10'(sum));
        end
    end

    // Lightness is sum * (2^F - 1) / 510 rounded. Splitting 2^F into a multiple of 510 and
    // a remainder leaves only a small division by 1020, done as a shift and a reciprocal.
    always_comb
    begin
        lit_base_full   = LBW'(c_sum_reg) * LBW'(LIT_A);
        d_lit_base_next = lit_base_full[F-1:0];
        lit_z           = ((19'(c_sum_reg) * 19'(LIT_B1)) << 1) + 19'(LIGHT_DEN);
        d_lit_y_next    = lit_z[18:2];
        lit_prod        = 35'(d_lit_y_reg) * 35'(LIT_RECIP);
        lit_next        = d_lit_base_reg + F'(lit_prod >> LIT_RECIP_SHIFT);
    end

    // Stage zero forms 2 * num * (2^F - 1) + den over 2 * den; each later stage decides
    // one quotient bit, most significant first.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem_next[0][l] = (((NW'(c_num_reg[l]) << F) - NW'(c_num_reg[l])) << 1)
                             + NW'(c_den_reg[l]);
            dvs_next[0][l] = {c_den_reg[l], 1'b0};
            q_next[0][l]   = '0;
        end
        for (int j = 1; j <= F; j++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (rem_reg[j-1][l] >= (NW'(dvs_reg[j-1][l]) << (F - j)))
                begin
                    rem_next[j][l] = rem_reg[j-1][l] - (NW'(dvs_reg[j-1][l]) << (F - j));
                    q_next[j][l]   = {q_reg[j-1][l][F-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][l] = rem_reg[j-1][l];
                    q_next[j][l]   = {q_reg[j-1][l][F-2:0], 1'b0};
                end
                dvs_next[j][l] = dvs_reg[j-1][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_A])
        begin
            a_pix_reg <= pixel;
        end
        if (adv[ST_B])
        begin
            b_red_reg   <= a_pix_reg.red;
            b_green_reg <= a_pix_reg.green;
            b_blue_reg  <= a_pix_reg.blue;
            b_max_reg   <= b_max_next;
            b_min_reg   <= b_min_next;
            b_rmax_reg  <= b_rmax_next;
            b_gmax_reg  <= b_gmax_next;
        end
        if (adv[ST_C])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                c_num_reg[l] <= c_num_next[l];
                c_den_reg[l] <= c_den_next[l];
            end
            c_sum_reg <= sum;
        end
        for (int j = 0; j <= F; j++)
        begin
            if (adv[ST_D + j])
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    dvs_reg[j][l] <= dvs_next[j][l];
                    q_reg[j][l]   <= q_next[j][l];
                end
            end
        end
        if (adv[ST_D])
        begin
            d_lit_base_reg <= d_lit_base_next;
            d_lit_y_reg    <= d_lit_y_next;
        end
        if (adv[ST_D + 1])
        begin
            lit_reg[0] <= lit_next;
        end
        for (int k = 1; k < F; k++)
        begin
            if (adv[ST_D + 1 + k])
            begin
                lit_reg[k] <= lit_reg[k-1];
            end
        end
    end

    assign hsl_valid      = valid_reg[NS-1];
    assign hsl.hue        = OUT_W'(q_reg[F][LANE_HUE]);
    assign hsl.saturation = OUT_W'(q_reg[F][LANE_SAT]);
    assign hsl.lightness  = OUT_W'(lit_reg[F-1]);

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (hsl_valid && hsl_stall && (&valid_reg)))
        else $error("pixel channel stalled while the pipeline has room");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_C] |-> (c_den_reg[LANE_HUE] != '0) && (c_den_reg[LANE_SAT] != '0))
        else $error("divider lane received a zero denominator");

    a_hue_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_C] |-> (NUM_W'(c_num_reg[LANE_HUE]) < NUM_W'(c_den_reg[LANE_HUE]))
                            || (c_num_reg[LANE_HUE] == '0))
        else $error("hue numerator outside one turn");

    a_remainder_small: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-1] |-> (rem_reg[F][LANE_HUE] < NW'(dvs_reg[F][LANE_HUE]))
                            && (rem_reg[F][LANE_SAT] < NW'(dvs_reg[F][LANE_SAT])))
        else $error("division left a remainder not below the divisor");
`endif

endmodule
